// File: rtl/sdsh_pkg.sv
// sdsh_pkg: types and constants shared by the SD SPI host sequencer.
// No dependencies.
package sdsh_pkg;

    localparam int BlockBytes = 512;
    localparam int CsdBytes   = 16;

    typedef enum logic [2:0] {
        K_INIT  = 3'd0,
        K_READ  = 3'd1,
        K_WRITE = 3'd2,
        K_CARD  = 3'd3,
        K_HOST  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        REG_POLL  = 3'd0,
        REG_DTOK  = 3'd1,
        REG_INIT  = 3'd2,
        REG_CTOK  = 3'd3,
        REG_SYNC  = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_IDLE  = 3'd1,
        ST_VOLT     = 3'd2,
        ST_INIT_TO  = 3'd3,
        ST_NO_RESP  = 3'd4,
        ST_CSD_FAIL = 3'd5,
        ST_XFER     = 3'd6
    } status_t;

    // input item
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] sector;
        logic [15:0] block_count;
        logic [7:0]  card_byte;
        logic [7:0]  host_byte;
    } in_item_t;

    // result item
    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        select_low;
        logic        clock_fast;
        logic        read_valid;
        logic [7:0]  read_data;
        logic        need_data;
        logic        done_res;
        logic [2:0]  status;
        logic [32:0] sector_count;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  poll_limit;
        logic [15:0] dtok_limit;
        logic [9:0]  init_limit;
        logic [7:0]  ctok_limit;
        logic [4:0]  sync_bytes;
    } cfg_t;

    localparam int CfgWidth = 16;

endpackage

// File: rtl/sdsh_if.sv
// sdsh_if: valid/ready channel carrying one item.
// Depends on nothing; payload type given as parameter.
interface sdsh_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/sd_spi_host_sequencer.sv
// sd_spi_host_sequencer: top level of the SD card SPI-mode host sequencer.
// Depends on sdsh_pkg, sdsh_if, sdsh_front, sdsh_back.
//
// Usage: the host sends items on chan_in: start init, start read, start
// write, a card byte (received for the previous sent byte) or a host write
// byte. Each accepted item yields at most one result on chan_out: a byte to
// send with its chip-select level, a read data byte, a request for write
// data, or a final status. Stray items (start while busy, unexpected bytes)
// give no result.
// Path: an accepted item is written into the input queue and, once the
// sequencer takes it, its result is registered in the output register.
// Throughput: one item per cycle unless a stalled receiver holds the result.
// A two-entry queue parts the input from the sequencer, and the result
// register is refilled in the cycle it is taken, so a stalled receiver
// backs up the queue only after two more items.
// Reset clears the sequencer to idle, limits to their defaults and the
// queue to empty. cfg writes belong between operations, with nothing in flight.
module sd_spi_host_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [sdsh_pkg::CfgWidth-1:0] cfg_data,
    sdsh_if.sink       chan_in,
    sdsh_if.source     chan_out
);
    import sdsh_pkg::*;

    cfg_t     cfg_reg;
    logic     q_valid, q_ready;
    in_item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_limit <= 8'd100;
            cfg_reg.dtok_limit <= 16'd25000;
            cfg_reg.init_limit <= 10'd400;
            cfg_reg.ctok_limit <= 8'd200;
            cfg_reg.sync_bytes <= 5'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POLL: cfg_reg.poll_limit <= cfg_data[7:0];
                REG_DTOK: cfg_reg.dtok_limit <= cfg_data;
                REG_INIT: cfg_reg.init_limit <= cfg_data[9:0];
                REG_CTOK: cfg_reg.ctok_limit <= cfg_data[7:0];
                REG_SYNC: cfg_reg.sync_bytes <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    sdsh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chan_in.valid),
        .in_ready (chan_in.ready),
        .in_item  (chan_in.payload),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    sdsh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (chan_out.valid),
        .out_ready (chan_out.ready),
        .out_item  (chan_out.payload)
    );

endmodule

// File: rtl/sdsh_front.sv
// sdsh_front: accepts input items, drops those of unknown kind, and queues the rest.
// Depends on sdsh_pkg.
module sdsh_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sdsh_pkg::in_item_t in_item,
    output logic              q_valid,
    input  logic              q_ready,
    output sdsh_pkg::in_item_t q_item
);
    import sdsh_pkg::*;

    // two-entry queue
    in_item_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop, legal;

    always_comb
    begin
        legal = (in_item.kind <= K_HOST);
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && legal;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not grow");

endmodule

// File: rtl/sdsh_back.sv
// sdsh_back: protocol sequencer, results to an output register.
// One queued item per cycle unless a held result is not taken. Depends on sdsh_pkg.
module sdsh_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sdsh_pkg::cfg_t     cfg,
    input  logic               q_valid,
    output logic               q_ready,
    input  sdsh_pkg::in_item_t q_item,
    output logic               out_valid,
    input  logic               out_ready,
    output sdsh_pkg::out_item_t out_item
);
    import sdsh_pkg::*;

    typedef enum logic [4:0] {
        P_IDLE, P_SYNC, P_CMD, P_POLL, P_GAP, P_ECHO, P_CTOK, P_CDATA, P_CCRC,
        P_RTOK, P_RDATA, P_RCRC, P_BUSYEND, P_WTOK, P_WNEED, P_WDATA, P_WCRC,
        P_WRESP, P_WBUSY, P_WSTOP
    } phase_t;
    typedef enum logic [3:0] {
        R_CMD0, R_CMD8, R_CMD55I, R_ACMD41, R_CMD9, R_RCMD, R_STOP,
        R_WCMD55, R_WACMD23, R_WCMD
    } resume_t;
    typedef enum logic [2:0] {
        G_CMD8, G_CMD55, G_ACMD41, G_CMD9, G_WACMD23, G_WCMD, G_FINISH
    } gap_t;

    phase_t      phase_reg, phase_next;
    resume_t     resume_reg, resume_next;
    gap_t        gap_reg, gap_next;
    logic [2:0]  gst_reg, gst_next;
    logic [9:0]  idx_reg, idx_next;
    logic [15:0] retry_reg, retry_next;
    logic [15:0] left_reg, left_next;
    logic        multi_reg, multi_next;
    logic [47:0] frame_reg, frame_next;
    logic [7:0]  lastr_reg, lastr_next;
    logic [31:0] echo_reg, echo_next;
    logic [21:0] csize_reg, csize_next;
    logic        fast_reg, fast_next;
    logic [9:0]  att_reg, att_next;
    logic [31:0] sect_reg, sect_next;
    logic [7:0]  csd7_reg, csd7_next, csd8_reg, csd8_next, csd9_reg, csd9_next;

    logic        res_v, txv, sel, rv, need, done;
    logic [7:0]  tx, rd;
    logic [2:0]  st;
    logic        take;
    logic [7:0]  b;
    logic [15:0] lim_poll, lim_dtok, lim_ctok;
    logic [9:0]  lim_init;
    logic [4:0]  lim_sync;
    logic [15:0] retry_inc;
    logic [9:0]  idx_inc;

    out_item_t   obuf_reg;
    logic        ovalid_reg;

    assign q_ready = !ovalid_reg || out_ready;
    assign take    = q_valid && q_ready;
    assign b       = q_item.card_byte;

    always_comb
    begin
        lim_poll  = (cfg.poll_limit == 8'd0) ? 16'd1 : {8'd0, cfg.poll_limit};
        lim_ctok  = (cfg.ctok_limit == 8'd0) ? 16'd1 : {8'd0, cfg.ctok_limit};
        lim_dtok  = (cfg.dtok_limit == 16'd0) ? 16'd1 : cfg.dtok_limit;
        lim_init  = (cfg.init_limit == 10'd0) ? 10'd1 : cfg.init_limit;
        lim_sync  = (cfg.sync_bytes == 5'd0) ? 5'd1 : cfg.sync_bytes;
        retry_inc = retry_reg + 16'd1;
        idx_inc   = idx_reg + 10'd1;
    end

    function automatic logic [7:0] fbyte(input logic [47:0] f, input logic [9:0] i);
        logic [7:0] r;
        unique case (i[2:0])
            3'd0:    r = f[47:40];
            3'd1:    r = f[39:32];
            3'd2:    r = f[31:24];
            3'd3:    r = f[23:16];
            3'd4:    r = f[15:8];
            default: r = f[7:0];
        endcase
        return r;
    endfunction

    always_comb
    begin
        logic [47:0] nf;
        logic        do_issue, do_gap, do_after, do_resp;
        logic [5:0]  icode;
        logic [31:0] iparam;
        logic [7:0]  icheck;
        resume_t     inext;
        gap_t        gnext;
        logic [2:0]  gstat;
        logic [7:0]  r;
        logic [9:0]  att1;

        phase_next = phase_reg; resume_next = resume_reg; gap_next = gap_reg;
        gst_next = gst_reg; idx_next = idx_reg; retry_next = retry_reg;
        left_next = left_reg; multi_next = multi_reg; frame_next = frame_reg;
        lastr_next = lastr_reg; echo_next = echo_reg; csize_next = csize_reg;
        fast_next = fast_reg; att_next = att_reg; sect_next = sect_reg;
        csd7_next = csd7_reg; csd8_next = csd8_reg; csd9_next = csd9_reg;
        res_v = 1'b0; txv = 1'b0; sel = 1'b0; tx = 8'd0; rv = 1'b0; rd = 8'd0;
        need = 1'b0; done = 1'b0; st = ST_OK;
        do_issue = 1'b0; do_gap = 1'b0; do_after = 1'b0; do_resp = 1'b0;
        icode = 6'd0; iparam = 32'd0; icheck = 8'hFF; inext = R_CMD0;
        gnext = G_FINISH; gstat = ST_OK; r = 8'hFF; att1 = att_reg + 10'd1;
        nf = 48'd0;

        if (take)
        begin
            priority case (q_item.kind)
                K_INIT, K_READ, K_WRITE:
                begin
                    if (phase_reg == P_IDLE)
                    begin
                        res_v = 1'b1;
                        if (q_item.kind == K_INIT)
                        begin
                            fast_next = 1'b0; idx_next = 10'd0; phase_next = P_SYNC;
                            txv = 1'b1; tx = 8'hFF;
                        end
                        else if (q_item.block_count == 16'd0)
                        begin
                            done = 1'b1; st = ST_OK;
                        end
                        else
                        begin
                            left_next  = q_item.block_count;
                            multi_next = (q_item.block_count > 16'd1);
                            sect_next  = q_item.sector;
                            do_issue   = 1'b1;
                            if (q_item.kind == K_READ)
                            begin
                                icode = multi_next ? 6'd18 : 6'd17;
                                iparam = q_item.sector; inext = R_RCMD;
                            end
                            else if (multi_next)
                            begin
                                icode = 6'd55; inext = R_WCMD55;
                            end
                            else
                            begin
                                icode = 6'd24; iparam = q_item.sector; inext = R_WCMD;
                            end
                        end
                    end
                end
                K_HOST:
                begin
                    if (phase_reg == P_WNEED)
                    begin
                        res_v = 1'b1; phase_next = P_WDATA;
                        txv = 1'b1; tx = q_item.host_byte; sel = 1'b1;
                    end
                end
                default:
                begin
                    if (phase_reg != P_IDLE && phase_reg != P_WNEED)
                    begin
                        res_v = 1'b1;
                        unique case (phase_reg)
                            P_SYNC:
                            begin
                                idx_next = idx_inc;
                                if (idx_inc < {5'd0, lim_sync})
                                begin
                                    txv = 1'b1; tx = 8'hFF;
                                end
                                else
                                begin
                                    do_issue = 1'b1; icode = 6'd0; icheck = 8'h95;
                                    inext = R_CMD0;
                                end
                            end
                            P_CMD:
                            begin
                                idx_next = idx_inc;
                                if (idx_inc < 10'd6)
                                begin
                                    txv = 1'b1; sel = 1'b1; tx = fbyte(frame_reg, idx_inc);
                                end
                                else
                                begin
                                    phase_next = P_POLL; retry_next = 16'd0;
                                    txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                                end
                            end
                            P_POLL:
                            begin
                                if (!b[7])
                                begin
                                    do_resp = 1'b1; r = b;
                                end
                                else
                                begin
                                    retry_next = retry_inc;
                                    if (retry_inc >= lim_poll)
                                    begin
                                        do_resp = 1'b1; r = 8'hFF;
                                    end
                                    else
                                    begin
                                        txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                                    end
                                end
                            end
                            P_GAP: do_after = 1'b1;
                            P_ECHO:
                            begin
                                echo_next = {echo_reg[23:0], b};
                                idx_next = idx_inc;
                                if (idx_inc < 10'd4)
                                begin
                                    txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                                end
                                else if (lastr_reg != 8'h01 || echo_next != 32'h1AA)
                                begin
                                    do_gap = 1'b1; gnext = G_FINISH; gstat = ST_VOLT;
                                end
                                else
                                begin
                                    att_next = 10'd0; do_gap = 1'b1; gnext = G_CMD55;
                                end
                            end
                            P_CTOK, P_RTOK:
                            begin
                                if (b == 8'hFE)
                                begin
                                    phase_next = (phase_reg == P_CTOK) ? P_CDATA : P_RDATA;
                                    idx_next = 10'd0; txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                                end
                                else
                                begin
                                    retry_next = retry_inc;
                                    if (retry_inc >= ((phase_reg == P_CTOK) ? lim_ctok
                                                                              : lim_dtok))
                                    begin
                                        do_gap = 1'b1; gnext = G_FINISH;
                                        gstat = (phase_reg == P_CTOK) ? ST_CSD_FAIL : ST_XFER;
                                    end
                                    else
                                    begin
                                        txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                                    end
                                end
                            end
                            P_CDATA:
                            begin
                                // only bytes 7..9 feed c_size
                                if (idx_reg[3:0] == 4'd7) csd7_next = b;
                                if (idx_reg[3:0] == 4'd8) csd8_next = b;
                                if (idx_reg[3:0] == 4'd9) csd9_next = b;
                                idx_next = idx_inc;
                                txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                                if (idx_inc >= 10'(CsdBytes))
                                begin
                                    csize_next = {csd7_reg[5:0], csd8_reg, csd9_reg};
                                    phase_next = P_CCRC; idx_next = 10'd0;
                                end
                            end
                            P_CCRC:
                            begin
                                idx_next = idx_inc;
                                if (idx_inc < 10'd2)
                                begin
                                    txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                                end
                                else
                                begin
                                    do_gap = 1'b1; gnext = G_FINISH;
                                end
                            end
                            P_RDATA:
                            begin
                                rv = 1'b1; rd = b; idx_next = idx_inc;
                                if ({1'b0, idx_inc} >= 11'(BlockBytes))
                                begin
                                    phase_next = P_RCRC; idx_next = 10'd0;
                                end
                                txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                            end
                            P_RCRC:
                            begin
                                idx_next = idx_inc;
                                if (idx_inc < 10'd2)
                                begin
                                    txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                                end
                                else
                                begin
                                    left_next = (left_reg != 16'd0) ? left_reg - 16'd1 : 16'd0;
                                    if (left_next != 16'd0)
                                    begin
                                        phase_next = P_RTOK; retry_next = 16'd0;
                                        txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                                    end
                                    else if (multi_reg)
                                    begin
                                        do_issue = 1'b1; icode = 6'd12; inext = R_STOP;
                                    end
                                    else
                                    begin
                                        do_gap = 1'b1; gnext = G_FINISH;
                                    end
                                end
                            end
                            P_BUSYEND:
                            begin
                                if (b == 8'hFF)
                                begin
                                    do_gap = 1'b1; gnext = G_FINISH;
                                end
                                else
                                begin
                                    txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                                end
                            end
                            P_WTOK:
                            begin
                                phase_next = P_WNEED; idx_next = 10'd0; need = 1'b1;
                            end
                            P_WDATA:
                            begin
                                idx_next = idx_inc;
                                if ({1'b0, idx_inc} < 11'(BlockBytes))
                                begin
                                    phase_next = P_WNEED; need = 1'b1;
                                end
                                else
                                begin
                                    phase_next = P_WCRC; idx_next = 10'd0;
                                    txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                                end
                            end
                            P_WCRC:
                            begin
                                idx_next = idx_inc;
                                if (idx_inc >= 10'd2) phase_next = P_WRESP;
                                txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                            end
                            P_WRESP:
                            begin
                                if (b[4:0] != 5'h05)
                                begin
                                    do_gap = 1'b1; gnext = G_FINISH; gstat = ST_XFER;
                                end
                                else
                                begin
                                    phase_next = P_WBUSY; txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                                end
                            end
                            P_WBUSY:
                            begin
                                if (b != 8'hFF)
                                begin
                                    txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                                end
                                else
                                begin
                                    left_next = (left_reg != 16'd0) ? left_reg - 16'd1 : 16'd0;
                                    if (left_next != 16'd0)
                                    begin
                                        phase_next = P_WTOK; txv = 1'b1; sel = 1'b1;
                                        tx = 8'hFC;
                                    end
                                    else if (multi_reg)
                                    begin
                                        phase_next = P_WSTOP; txv = 1'b1; sel = 1'b1;
                                        tx = 8'hFD;
                                    end
                                    else
                                    begin
                                        do_gap = 1'b1; gnext = G_FINISH;
                                    end
                                end
                            end
                            P_WSTOP:
                            begin
                                phase_next = P_BUSYEND; txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end

        // response to a polled command
        if (do_resp)
        begin
            lastr_next = r;
            unique case (resume_reg)
                R_CMD0:
                begin
                    do_gap = 1'b1;
                    gnext = (r != 8'h01) ? G_FINISH : G_CMD8;
                    gstat = (r != 8'h01) ? ST_NO_IDLE : ST_OK;
                end
                R_CMD8:
                begin
                    phase_next = P_ECHO; idx_next = 10'd0; echo_next = 32'd0;
                    txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                end
                R_CMD55I:
                begin
                    do_gap = 1'b1;
                    gnext = (r == 8'hFF) ? G_FINISH : G_ACMD41;
                    gstat = (r == 8'hFF) ? ST_NO_RESP : ST_OK;
                end
                R_ACMD41:
                begin
                    do_gap = 1'b1;
                    if (r == 8'hFF)
                    begin
                        gnext = G_FINISH; gstat = ST_NO_RESP;
                    end
                    else if (r == 8'h00)
                    begin
                        gnext = G_CMD9;
                    end
                    else
                    begin
                        att_next = att1;
                        if (att1 == 10'd0 || att1 >= lim_init)
                        begin
                            gnext = G_FINISH; gstat = ST_INIT_TO;
                        end
                        else
                        begin
                            gnext = G_CMD55;
                        end
                    end
                end
                R_CMD9, R_RCMD:
                begin
                    if (r != 8'h00)
                    begin
                        do_gap = 1'b1; gnext = G_FINISH;
                        gstat = (resume_reg == R_CMD9) ? ST_CSD_FAIL : ST_XFER;
                    end
                    else
                    begin
                        phase_next = (resume_reg == R_CMD9) ? P_CTOK : P_RTOK;
                        retry_next = 16'd0; txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                    end
                end
                R_STOP:
                begin
                    phase_next = P_BUSYEND; txv = 1'b1; sel = 1'b1; tx = 8'hFF;
                end
                R_WCMD55:  begin do_gap = 1'b1; gnext = G_WACMD23; end
                R_WACMD23: begin do_gap = 1'b1; gnext = G_WCMD; end
                default:
                begin
                    if (r != 8'h00)
                    begin
                        do_gap = 1'b1; gnext = G_FINISH; gstat = ST_XFER;
                    end
                    else
                    begin
                        phase_next = P_WTOK; txv = 1'b1; sel = 1'b1;
                        tx = multi_reg ? 8'hFC : 8'hFE;
                    end
                end
            endcase
        end

        // command, or final status, after a deselect gap
        if (do_after)
        begin
            unique case (gap_reg)
                G_CMD8:
                begin
                    do_issue = 1'b1; icode = 6'd8; iparam = 32'h1AA; icheck = 8'h87;
                    inext = R_CMD8;
                end
                G_CMD55:   begin do_issue = 1'b1; icode = 6'd55; inext = R_CMD55I; end
                G_ACMD41:
                begin
                    do_issue = 1'b1; icode = 6'd41; iparam = 32'h4000_0000;
                    inext = R_ACMD41;
                end
                G_CMD9:
                begin
                    fast_next = 1'b1; do_issue = 1'b1; icode = 6'd9; inext = R_CMD9;
                end
                G_WACMD23:
                begin
                    do_issue = 1'b1; icode = 6'd23; iparam = {16'd0, left_reg};
                    inext = R_WACMD23;
                end
                G_WCMD:
                begin
                    do_issue = 1'b1; icode = multi_reg ? 6'd25 : 6'd24;
                    iparam = sect_reg; inext = R_WCMD;
                end
                default:
                begin
                    done = 1'b1; st = gst_reg; phase_next = P_IDLE;
                end
            endcase
        end

        if (do_gap)
        begin
            gap_next = gnext; gst_next = gstat; phase_next = P_GAP;
            txv = 1'b1; sel = 1'b0; tx = 8'hFF;
        end

        if (do_issue)
        begin
            nf = {2'b01, icode, iparam, icheck};
            frame_next = nf; idx_next = 10'd0; resume_next = inext; phase_next = P_CMD;
            txv = 1'b1; sel = 1'b1; tx = nf[47:40];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE; resume_reg <= R_CMD0; gap_reg <= G_CMD8;
            gst_reg <= 3'd0; idx_reg <= 10'd0; retry_reg <= 16'd0; left_reg <= 16'd0;
            multi_reg <= 1'b0; frame_reg <= 48'd0; lastr_reg <= 8'hFF;
            echo_reg <= 32'd0; csize_reg <= 22'd0; fast_reg <= 1'b0; att_reg <= 10'd0;
            sect_reg <= 32'd0; ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; resume_reg <= resume_next; gap_reg <= gap_next;
            gst_reg <= gst_next; idx_reg <= idx_next; retry_reg <= retry_next;
            left_reg <= left_next; multi_reg <= multi_next; frame_reg <= frame_next;
            lastr_reg <= lastr_next; echo_reg <= echo_next; csize_reg <= csize_next;
            fast_reg <= fast_next; att_reg <= att_next; sect_reg <= sect_next;
            if (take)
                ovalid_reg <= res_v;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        csd7_reg <= csd7_next;
        csd8_reg <= csd8_next;
        csd9_reg <= csd9_next;
        if (take && res_v)
        begin
            obuf_reg.tx_valid     <= txv;
            obuf_reg.tx_byte      <= tx;
            obuf_reg.select_low   <= sel;
            obuf_reg.clock_fast   <= fast_next;
            obuf_reg.read_valid   <= rv;
            obuf_reg.read_data    <= rd;
            obuf_reg.need_data    <= need;
            obuf_reg.done_res     <= done;
            obuf_reg.status       <= st;
            obuf_reg.sector_count <= {1'b0, csize_next + 22'd1, 10'd0}
                                     + {(csize_next == 22'h3FFFFF), 32'd0};
        end
    end

    assign out_valid = ovalid_reg;
    assign out_item  = obuf_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({out_item.tx_valid, out_item.need_data,
                                  out_item.done_res}) == 1) else $error("result mix");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (take && done) |=> phase_reg == P_IDLE) else $error("done not idle");

endmodule

// File: dv/tb_sd_spi_host_sequencer.sv
// Self-checking testbench for sd_spi_host_sequencer: directed table, then a
// card-responder driven random run checked against an in-bench sequencer model.
// Depends on rtl/sdsh_pkg.sv, rtl/sdsh_if.sv and the RTL of the block.
`timescale 1ns / 100ps

module tb_sd_spi_host_sequencer;
    import sdsh_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_SYNC, PH_CMD, PH_POLL, PH_GAP, PH_ECHO, PH_CTOK, PH_CDATA,
        PH_CCRC, PH_RTOK, PH_RDATA, PH_RCRC, PH_BUSYEND, PH_WTOK, PH_WNEED,
        PH_WDATA, PH_WCRC, PH_WRESP, PH_WBUSY, PH_WSTOP
    } seq_phase_t;

    typedef enum logic [3:0] {
        RS_CMD0, RS_CMD8, RS_CMD55I, RS_ACMD41, RS_CMD9, RS_RCMD, RS_STOP,
        RS_WCMD55, RS_WACMD23, RS_WCMD
    } resp_step_t;

    typedef enum logic [2:0] {
        GS_CMD8, GS_CMD55, GS_ACMD41, GS_CMD9, GS_WACMD23, GS_WCMD, GS_FINISH
    } gap_step_t;

    localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
    localparam logic [5:0] CMD_IF_COND      = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
    localparam logic [5:0] CMD_STOP         = 6'd12;
    localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
    localparam logic [5:0] CMD_READ_MULTI   = 6'd18;
    localparam logic [5:0] CMD_SET_BLOCKS   = 6'd23;
    localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
    localparam logic [5:0] CMD_WRITE_MULTI  = 6'd25;
    localparam logic [5:0] CMD_OP_COND      = 6'd41;
    localparam logic [5:0] CMD_APP          = 6'd55;

    localparam logic [7:0]  CRC_CMD0     = 8'h95;
    localparam logic [7:0]  CRC_CMD8     = 8'h87;
    localparam logic [7:0]  NO_CRC       = 8'hFF;
    localparam logic [7:0]  FILL_BYTE    = 8'hFF;
    localparam logic [7:0]  TOKEN_START  = 8'hFE;
    localparam logic [7:0]  TOKEN_MULTI  = 8'hFC;
    localparam logic [7:0]  TOKEN_STOP   = 8'hFD;
    localparam logic [7:0]  R1_IDLE      = 8'h01;
    localparam logic [7:0]  R1_READY     = 8'h00;
    localparam logic [7:0]  R1_ILLEGAL   = 8'h04;
    localparam logic [7:0]  DATA_ACCEPT  = 8'h05;
    localparam logic [7:0]  RESP_MASK    = 8'h1F;
    localparam logic [31:0] IF_COND_ARG  = 32'h0000_01AA;
    localparam logic [31:0] HCS_ARG      = 32'h4000_0000;

    localparam int PHASE_ITEMS = 100;
    localparam int SETTLE      = 6;
    localparam int STALL_LIMIT = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [CfgWidth-1:0] cfg_data = '0;

    sdsh_if #(.payload_t(in_item_t))  in_ch ();
    sdsh_if #(.payload_t(out_item_t)) out_ch ();

    sd_spi_host_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chan_in   (in_ch),
        .chan_out  (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sequencer model state
    logic [7:0]  lim_poll;
    logic [15:0] lim_dtok;
    logic [9:0]  lim_init;
    logic [7:0]  lim_ctok;
    logic [4:0]  lim_sync;
    seq_phase_t  ph;
    int          idx;
    logic [15:0] retries;
    logic [15:0] blocks;
    bit          multi;
    logic [47:0] frame;
    logic [7:0]  r1_last;
    logic [31:0] echo;
    logic [7:0]  csd [CsdBytes];
    logic [21:0] c_size;
    bit          fast;
    resp_step_t  resume;
    gap_step_t   gnext;
    status_t     gstat;
    logic [9:0]  rounds;
    logic [31:0] lba;
    out_item_t   nr;

    out_item_t expected_results [$];
    int fails = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;

    function automatic void model_reset();
        lim_poll = 8'd100; lim_dtok = 16'd25000; lim_init = 10'd400;
        lim_ctok = 8'd200; lim_sync = 5'd10;
        ph = PH_IDLE; idx = 0; retries = '0; blocks = '0; multi = 0;
        frame = '0; r1_last = 8'hFF; echo = '0; c_size = '0; fast = 0;
        resume = RS_CMD0; gnext = GS_CMD8; gstat = ST_OK; rounds = '0; lba = '0;
    endfunction

    function automatic void model_config(reg_idx_t r, logic [15:0] v);
        case (r)
            REG_POLL: lim_poll = v[7:0];
            REG_DTOK: lim_dtok = v;
            REG_INIT: lim_init = v[9:0];
            REG_CTOK: lim_ctok = v[7:0];
            REG_SYNC: lim_sync = v[4:0];
            default: ;
        endcase
    endfunction

    function automatic logic [15:0] floor1(logic [15:0] v);
        return (v == 0) ? 16'd1 : v;
    endfunction

    function automatic void send(logic [7:0] b, bit low);
        nr.tx_valid = 1'b1; nr.tx_byte = b; nr.select_low = low;
    endfunction

    function automatic void conclude(status_t s);
        nr.done_res = 1'b1; nr.status = s; ph = PH_IDLE;
    endfunction

    function automatic logic [7:0] frame_at(int i);
        logic [47:0] t;
        t = frame >> (40 - 8 * (i % 6));
        return t[7:0];
    endfunction

    function automatic void issue(logic [5:0] code, logic [31:0] arg, logic [7:0] crc,
                                  resp_step_t nxt);
        frame = {2'b01, code, arg, crc};
        idx = 0; resume = nxt; ph = PH_CMD;
        send(frame_at(0), 1'b1);
    endfunction

    function automatic void deselect(gap_step_t nxt, status_t s);
        gnext = nxt; gstat = s; ph = PH_GAP;
        send(FILL_BYTE, 1'b0);
    endfunction

    function automatic void after_deselect();
        case (gnext)
            GS_CMD8:    issue(CMD_IF_COND, IF_COND_ARG, CRC_CMD8, RS_CMD8);
            GS_CMD55:   issue(CMD_APP, '0, NO_CRC, RS_CMD55I);
            GS_ACMD41:  issue(CMD_OP_COND, HCS_ARG, NO_CRC, RS_ACMD41);
            GS_CMD9:
            begin
                fast = 1;
                issue(CMD_SEND_CSD, '0, NO_CRC, RS_CMD9);
            end
            GS_WACMD23: issue(CMD_SET_BLOCKS, {16'd0, blocks}, NO_CRC, RS_WACMD23);
            GS_WCMD:    issue(multi ? CMD_WRITE_MULTI : CMD_WRITE_SINGLE, lba, NO_CRC, RS_WCMD);
            default:    conclude(gstat);
        endcase
    endfunction

    function automatic void on_r1(logic [7:0] r);
        r1_last = r;
        case (resume)
            RS_CMD0:
                if (r != R1_IDLE) deselect(GS_FINISH, ST_NO_IDLE);
                else deselect(GS_CMD8, ST_OK);
            RS_CMD8:
            begin
                ph = PH_ECHO; idx = 0; echo = '0; send(FILL_BYTE, 1'b1);
            end
            RS_CMD55I:
                if (r == 8'hFF) deselect(GS_FINISH, ST_NO_RESP);
                else deselect(GS_ACMD41, ST_OK);
            RS_ACMD41:
                if (r == 8'hFF) deselect(GS_FINISH, ST_NO_RESP);
                else if (r == R1_READY) deselect(GS_CMD9, ST_OK);
                else
                begin
                    rounds = rounds + 10'd1;
                    if (rounds == 0 || rounds >= floor1(lim_init))
                        deselect(GS_FINISH, ST_INIT_TO);
                    else
                        deselect(GS_CMD55, ST_OK);
                end
            RS_CMD9:
                if (r != R1_READY) deselect(GS_FINISH, ST_CSD_FAIL);
                else
                begin
                    ph = PH_CTOK; retries = '0; send(FILL_BYTE, 1'b1);
                end
            RS_RCMD:
                if (r != R1_READY) deselect(GS_FINISH, ST_XFER);
                else
                begin
                    ph = PH_RTOK; retries = '0; send(FILL_BYTE, 1'b1);
                end
            RS_STOP:
            begin
                ph = PH_BUSYEND; send(FILL_BYTE, 1'b1);
            end
            RS_WCMD55:  deselect(GS_WACMD23, ST_OK);
            RS_WACMD23: deselect(GS_WCMD, ST_OK);
            default:
                if (r != R1_READY) deselect(GS_FINISH, ST_XFER);
                else
                begin
                    ph = PH_WTOK; send(multi ? TOKEN_MULTI : TOKEN_START, 1'b1);
                end
        endcase
    endfunction

    function automatic void end_of_block(bit is_read);
        if (blocks > 0) blocks = blocks - 16'd1;
        if (blocks > 0)
        begin
            if (is_read)
            begin
                ph = PH_RTOK; retries = '0; send(FILL_BYTE, 1'b1);
            end
            else
            begin
                ph = PH_WTOK; send(TOKEN_MULTI, 1'b1);
            end
        end
        else if (multi)
        begin
            if (is_read) issue(CMD_STOP, '0, NO_CRC, RS_STOP);
            else
            begin
                ph = PH_WSTOP; send(TOKEN_STOP, 1'b1);
            end
        end
        else deselect(GS_FINISH, ST_OK);
    endfunction

    function automatic void on_card_byte(logic [7:0] b);
        case (ph)
            PH_SYNC:
            begin
                idx++;
                if (idx < floor1(lim_sync)) send(FILL_BYTE, 1'b0);
                else issue(CMD_GO_IDLE, '0, CRC_CMD0, RS_CMD0);
            end
            PH_CMD:
            begin
                idx++;
                if (idx < 6) send(frame_at(idx), 1'b1);
                else
                begin
                    ph = PH_POLL; retries = '0; send(FILL_BYTE, 1'b1);
                end
            end
            PH_POLL:
                if (!b[7]) on_r1(b);
                else
                begin
                    retries = retries + 16'd1;
                    if (retries >= floor1(lim_poll)) on_r1(8'hFF);
                    else send(FILL_BYTE, 1'b1);
                end
            PH_GAP: after_deselect();
            PH_ECHO:
            begin
                echo = {echo[23:0], b};
                idx++;
                if (idx < 4) send(FILL_BYTE, 1'b1);
                else if (r1_last != R1_IDLE || echo != IF_COND_ARG)
                    deselect(GS_FINISH, ST_VOLT);
                else
                begin
                    rounds = '0; deselect(GS_CMD55, ST_OK);
                end
            end
            PH_CTOK:
                if (b == TOKEN_START)
                begin
                    ph = PH_CDATA; idx = 0; send(FILL_BYTE, 1'b1);
                end
                else
                begin
                    retries = retries + 16'd1;
                    if (retries >= floor1(lim_ctok)) deselect(GS_FINISH, ST_CSD_FAIL);
                    else send(FILL_BYTE, 1'b1);
                end
            PH_CDATA:
            begin
                csd[idx % CsdBytes] = b;
                idx++;
                if (idx >= CsdBytes)
                begin
                    c_size = {csd[7][5:0], csd[8], csd[9]};
                    ph = PH_CCRC; idx = 0;
                end
                send(FILL_BYTE, 1'b1);
            end
            PH_CCRC:
            begin
                idx++;
                if (idx < 2) send(FILL_BYTE, 1'b1);
                else deselect(GS_FINISH, ST_OK);
            end
            PH_RTOK:
                if (b == TOKEN_START)
                begin
                    ph = PH_RDATA; idx = 0; send(FILL_BYTE, 1'b1);
                end
                else
                begin
                    retries = retries + 16'd1;
                    if (retries >= floor1(lim_dtok)) deselect(GS_FINISH, ST_XFER);
                    else send(FILL_BYTE, 1'b1);
                end
            PH_RDATA:
            begin
                nr.read_valid = 1'b1; nr.read_data = b;
                idx++;
                if (idx >= BlockBytes)
                begin
                    ph = PH_RCRC; idx = 0;
                end
                send(FILL_BYTE, 1'b1);
            end
            PH_RCRC:
            begin
                idx++;
                if (idx < 2) send(FILL_BYTE, 1'b1);
                else end_of_block(1'b1);
            end
            PH_BUSYEND:
                if (b == 8'hFF) deselect(GS_FINISH, ST_OK);
                else send(FILL_BYTE, 1'b1);
            PH_WTOK:
            begin
                ph = PH_WNEED; idx = 0; nr.need_data = 1'b1;
            end
            PH_WDATA:
            begin
                idx++;
                if (idx < BlockBytes)
                begin
                    ph = PH_WNEED; nr.need_data = 1'b1;
                end
                else
                begin
                    ph = PH_WCRC; idx = 0; send(FILL_BYTE, 1'b1);
                end
            end
            PH_WCRC:
            begin
                idx++;
                if (idx >= 2) ph = PH_WRESP;
                send(FILL_BYTE, 1'b1);
            end
            PH_WRESP:
                if ((b & RESP_MASK) != DATA_ACCEPT) deselect(GS_FINISH, ST_XFER);
                else
                begin
                    ph = PH_WBUSY; send(FILL_BYTE, 1'b1);
                end
            PH_WBUSY:
                if (b != 8'hFF) send(FILL_BYTE, 1'b1);
                else end_of_block(1'b0);
            default:
            begin
                ph = PH_BUSYEND; send(FILL_BYTE, 1'b1);
            end
        endcase
    endfunction

    // returns 1 when the item yields a result, placed in r
    function automatic bit model_step(in_item_t it, output out_item_t r);
        nr = '0;
        r = '0;
        case (it.kind)
            K_INIT, K_READ, K_WRITE:
            begin
                if (ph != PH_IDLE) return 0;
                if (it.kind == K_INIT)
                begin
                    fast = 0; idx = 0; ph = PH_SYNC; send(FILL_BYTE, 1'b0);
                end
                else if (it.block_count == 0) conclude(ST_OK);
                else
                begin
                    blocks = it.block_count; multi = it.block_count > 1; lba = it.sector;
                    if (it.kind == K_READ)
                        issue(multi ? CMD_READ_MULTI : CMD_READ_SINGLE, it.sector, NO_CRC,
                              RS_RCMD);
                    else if (multi) issue(CMD_APP, '0, NO_CRC, RS_WCMD55);
                    else issue(CMD_WRITE_SINGLE, it.sector, NO_CRC, RS_WCMD);
                end
            end
            K_CARD:
            begin
                if (ph == PH_IDLE || ph == PH_WNEED) return 0;
                on_card_byte(it.card_byte);
            end
            K_HOST:
            begin
                if (ph != PH_WNEED) return 0;
                ph = PH_WDATA;
                send(it.host_byte, 1'b1);
            end
            default: return 0;
        endcase
        nr.clock_fast = fast;
        nr.sector_count = ({11'd0, c_size} + 33'd1) << 10;
        r = nr;
        return 1;
    endfunction

    // card responder: mostly the answer a healthy card gives, some noise
    function automatic logic [7:0] card_answer();
        int roll;
        roll = $urandom_range(99);
        case (ph)
            PH_POLL:
                if (roll < 15) return 8'h80 | 8'($urandom_range(127));
                else if (roll < 22) return 8'($urandom_range(127));
                else
                    case (resume)
                        RS_CMD0, RS_CMD8, RS_CMD55I: return R1_IDLE;
                        RS_ACMD41: return ($urandom_range(2) == 0) ? R1_READY : R1_IDLE;
                        RS_STOP, RS_WCMD55, RS_WACMD23: return 8'($urandom_range(127));
                        // block commands are mostly refused, which keeps the run short
                        RS_RCMD, RS_WCMD: return R1_ILLEGAL;
                        default: return R1_READY;
                    endcase
            PH_ECHO:
                if (roll < 8) return 8'($urandom_range(255));
                else return IF_COND_ARG[8 * (3 - idx) +: 8];
            PH_CTOK, PH_RTOK:
                if (roll < 45) return TOKEN_START;
                else if (roll < 85) return 8'hFF;
                else return 8'($urandom_range(255));
            PH_BUSYEND, PH_WBUSY:
                return (roll < 35) ? 8'hFF : 8'($urandom_range(255));
            PH_WRESP:
                if (roll < 85) return (8'($urandom_range(255)) & 8'hE0) | DATA_ACCEPT;
                else return 8'($urandom_range(255));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic in_item_t next_item();
        in_item_t it;
        int roll;
        it.sector = $urandom;
        it.block_count = 16'($urandom);
        it.card_byte = 8'($urandom_range(255));
        it.host_byte = 8'($urandom_range(255));
        roll = $urandom_range(99);
        if (ph == PH_IDLE)
        begin
            if (roll < 8)
                it.kind = 3'($urandom_range(7)) | 3'd3;
            else
            begin
                roll = $urandom_range(99);
                it.kind = (roll < 35) ? K_INIT : (roll < 65) ? K_READ : K_WRITE;
                roll = $urandom_range(99);
                it.block_count = (roll < 8) ? 16'd0 : (roll < 78) ? 16'd1 :
                                 (roll < 98) ? 16'd2 : 16'd3;
                roll = $urandom_range(9);
                if (roll == 0) it.sector = '0;
                else if (roll == 1) it.sector = '1;
            end
        end
        else if (ph == PH_WNEED)
            it.kind = (roll < 95) ? K_HOST : K_CARD;
        else if (roll < 3)
            it.kind = 3'($urandom_range(2));
        else if (roll < 5)
            it.kind = 3'($urandom_range(7, 4));
        else
        begin
            it.kind = K_CARD;
            it.card_byte = card_answer();
        end
        return it;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
        fails++;
    endtask

    task automatic push_item(in_item_t it, bit typed, bit yields, out_item_t want,
                             output bit got);
        out_item_t pred;
        @(negedge clk);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        got = model_step(it, pred);
        if (typed)
        begin
            if (yields) expected_results.push_back(want);
        end
        else if (got)
            expected_results.push_back(pred);
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t r, logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        model_config(r, v);
        @(negedge clk);
    endtask

    function automatic out_item_t want_tx(logic [7:0] b, bit low);
        out_item_t w;
        w = '0;
        w.tx_valid = 1'b1; w.tx_byte = b; w.select_low = low;
        w.sector_count = 33'd1024;
        return w;
    endfunction

    function automatic out_item_t want_done(status_t s);
        out_item_t w;
        w = '0;
        w.done_res = 1'b1; w.status = s;
        w.sector_count = 33'd1024;
        return w;
    endfunction

    function automatic in_item_t mk(logic [2:0] k, logic [31:0] s, logic [15:0] c,
                                    logic [7:0] cb, logic [7:0] hb);
        in_item_t it;
        it.kind = k; it.sector = s; it.block_count = c; it.card_byte = cb; it.host_byte = hb;
        return it;
    endfunction

    // receiver stalls
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);

    always @(posedge clk)
    begin
        out_item_t w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
                flag_mismatch("result with none expected", 64'(out_ch.payload), '0);
            else
            begin
                w = expected_results.pop_front();
                if (out_ch.payload.tx_valid !== w.tx_valid)
                    flag_mismatch("tx_valid", out_ch.payload.tx_valid, w.tx_valid);
                if (out_ch.payload.tx_byte !== w.tx_byte)
                    flag_mismatch("tx_byte", out_ch.payload.tx_byte, w.tx_byte);
                if (out_ch.payload.select_low !== w.select_low)
                    flag_mismatch("select_low", out_ch.payload.select_low, w.select_low);
                if (out_ch.payload.clock_fast !== w.clock_fast)
                    flag_mismatch("clock_fast", out_ch.payload.clock_fast, w.clock_fast);
                if (out_ch.payload.read_valid !== w.read_valid)
                    flag_mismatch("read_valid", out_ch.payload.read_valid, w.read_valid);
                if (out_ch.payload.read_data !== w.read_data)
                    flag_mismatch("read_data", out_ch.payload.read_data, w.read_data);
                if (out_ch.payload.need_data !== w.need_data)
                    flag_mismatch("need_data", out_ch.payload.need_data, w.need_data);
                if (out_ch.payload.done_res !== w.done_res)
                    flag_mismatch("done_res", out_ch.payload.done_res, w.done_res);
                if (out_ch.payload.status !== w.status)
                    flag_mismatch("status", out_ch.payload.status, w.status);
                if (out_ch.payload.sector_count !== w.sector_count)
                    flag_mismatch("sector_count", out_ch.payload.sector_count,
                                  w.sector_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        in_item_t it;
        bit got;
        int produced;
        bit paused;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        model_reset();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: stray items, zero counts, busy starts, start of init
        push_item(mk(K_CARD, '0, '0, 8'hA5, 8'h00), 1, 0, '0, got);
        push_item(mk(K_HOST, '1, '1, 8'h00, 8'hFF), 1, 0, '0, got);
        push_item(mk(3'd5, '1, '1, 8'hFF, 8'hFF), 1, 0, '0, got);
        push_item(mk(3'd6, '0, '0, 8'h00, 8'h00), 1, 0, '0, got);
        push_item(mk(3'd7, '1, '1, 8'hFF, 8'hFF), 1, 0, '0, got);
        push_item(mk(K_READ, '1, '0, 8'h00, 8'h00), 1, 1, want_done(ST_OK), got);
        push_item(mk(K_WRITE, '0, '0, 8'h00, 8'h00), 1, 1, want_done(ST_OK), got);
        push_item(mk(K_INIT, '0, '0, 8'h00, 8'h00), 1, 1, want_tx(FILL_BYTE, 0), got);
        push_item(mk(K_READ, '1, '1, 8'h00, 8'h00), 1, 0, '0, got);
        push_item(mk(K_WRITE, 32'h8000_0000, 16'h8000, 8'h00, 8'h00), 1, 0, '0, got);
        push_item(mk(K_HOST, '0, '0, 8'h00, 8'h5A), 1, 0, '0, got);
        for (int i = 0; i < 9; i++)
            push_item(mk(K_CARD, '0, '0, (i % 2) ? 8'hFF : 8'h00, 8'h00), 1, 1,
                      want_tx(FILL_BYTE, 0), got);
        push_item(mk(K_CARD, '0, '0, 8'h7E, 8'h00), 1, 1,
                  want_tx(8'h40 | 8'(CMD_GO_IDLE), 1), got);

        for (int p = 0; p < 4; p++)
        begin
            if (p > 0)
            begin
                drain();
                case (p)
                    1:
                    begin
                        write_reg(REG_POLL, 16'd1); write_reg(REG_DTOK, 16'd1);
                        write_reg(REG_INIT, 16'd1); write_reg(REG_CTOK, 16'd1);
                        write_reg(REG_SYNC, 16'd1);
                    end
                    2:
                    begin
                        write_reg(REG_POLL, 16'd255); write_reg(REG_DTOK, 16'd65535);
                        write_reg(REG_INIT, 16'd1023); write_reg(REG_CTOK, 16'd255);
                        write_reg(REG_SYNC, 16'd31);
                    end
                    default:
                    begin
                        // zero limits behave as one
                        write_reg(REG_POLL, 16'd3); write_reg(REG_DTOK, 16'd0);
                        write_reg(REG_INIT, 16'd2); write_reg(REG_CTOK, 16'd0);
                        write_reg(REG_SYNC, 16'd0);
                    end
                endcase
                cfg_we <= 1'b0;
            end
            tx_gap_pct = (p == 1) ? 51 : (p == 3) ? 19 : 0;
            rx_stall_pct = (p == 2) ? 51 : (p == 3) ? 19 : 0;
            produced = 0;
            paused = 0;
            while (produced < PHASE_ITEMS || ph != PH_IDLE)
            begin
                if (p == 1 && produced == 70 && !paused)
                begin
                    drain();
                    paused = 1;
                end
                it = next_item();
                push_item(it, 0, 0, '0, got);
                produced++;
            end
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
